### hdl/scfl_pkg.sv
// Shared types and constants for the size-class free-list allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package scfl_pkg;

  // Pool geometry
  localparam int POOL_BYTES      = 1048576;
  localparam int GRANULE_BYTES   = 32;
  localparam int GRAN_SHIFT      = $clog2(GRANULE_BYTES);
  localparam int GRAN_COUNT      = POOL_BYTES / GRANULE_BYTES;
  localparam int GRAN_W          = $clog2(GRAN_COUNT);

  // Size classes: class c holds blocks of MIN_CLASS_BYTES << c
  localparam int NUM_CLASSES     = 8;
  localparam int MIN_CLASS_BYTES = 32;
  localparam int CLS_W           = 4;
  localparam int CLS_IDX_W       = $clog2(NUM_CLASSES);

  // Field widths
  localparam int ADDR_W          = 20;
  localparam int REQ_W           = 21;
  localparam int LIMIT_W         = 21;
  localparam int SUM_W           = REQ_W + 1;
  localparam int STATUS_W        = 3;

  // Bump limit at reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

  // Register map (word index)
  localparam logic REG_REGION_LIMIT = 1'b0;

  // Operation codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_REUSED  = 3'd0,
    STAT_FRESH   = 3'd1,
    STAT_OOM     = 3'd2,
    STAT_FREED   = 3'd3,
    STAT_DROPPED = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming beat, start the link read
    logic execute;  // resolve the item and load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } dp_stat_t;

  // Smallest class whose block size covers the request; NUM_CLASSES when oversize
  function automatic logic [CLS_W-1:0] class_of(input logic [REQ_W-1:0] bytes);
    logic [CLS_W-1:0] cls;
    cls = CLS_W'(NUM_CLASSES);
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (bytes <= REQ_W'(MIN_CLASS_BYTES << c)) begin
        cls = CLS_W'(c);
      end
    end
    return cls;
  endfunction

endpackage

### hdl/scfl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the link store of the allocator.
`timescale 1ns / 1ps

module scfl_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 32768,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read with output held until the next enabled read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/scfl_ctrl.sv
// Controller state machine of the allocator: accepts a beat, then resolves it.
// Depends on scfl_pkg for the state and command/status types.
`timescale 1ns / 1ps

module scfl_ctrl
  import scfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a beat in ST_IDLE, resolve it in ST_EXEC when out_free
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs; hold off the request side while in reset
  always_comb begin
    in_ready    = 1'b0;
    ctl.accept  = 1'b0;
    ctl.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        ctl.accept = in_valid && !rst;
      end
      ST_EXEC: begin
        ctl.execute = stat.out_free;
      end
      default: ;
    endcase
  end

  // Never take a beat while resolving one
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.accept && ctl.execute))
    else $error("accept and execute in the same cycle");

  // An accepted beat is followed by the resolve state
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> (state == ST_EXEC))
    else $error("accepted beat not followed by resolve");

  // Resolve only with room in the output register
  a_exec_room: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |-> stat.out_free)
    else $error("resolve without output room");

endmodule

### hdl/scfl_dp.sv
// Datapath of the allocator: class decode, list heads, link store, bump carver,
// output register. Depends on scfl_pkg and scfl_ram.
`timescale 1ns / 1ps

module scfl_dp
  import scfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            ctl,
  output dp_stat_t           stat,
  input  logic               in_cmd,
  input  logic [REQ_W-1:0]   in_req,
  input  logic [ADDR_W-1:0]  in_baddr,
  input  logic [LIMIT_W-1:0] region_limit,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_addr,
  output logic [STATUS_W-1:0] out_status,
  output logic [CLS_W-1:0]   out_class
);

  // List heads
  logic              head_valid [NUM_CLASSES];
  logic [GRAN_W-1:0] head_gran  [NUM_CLASSES];

  // Item registers
  logic              item_cmd;
  logic [REQ_W-1:0]  item_req;
  logic [ADDR_W-1:0] item_baddr;
  logic [CLS_W-1:0]  item_class;
  logic              item_hvalid;
  logic [GRAN_W-1:0] item_hgran;

  logic [LIMIT_W-1:0] bump;
  logic [LIMIT_W-1:0] bump_next;

  logic [CLS_W-1:0]     class_in;
  logic [CLS_IDX_W-1:0] class_in_idx;
  logic [CLS_IDX_W-1:0] ci;
  logic                 is_cls;
  logic [GRAN_W-1:0]    free_gran;
  logic [GRAN_W-1:0]    link_rd;
  logic [GRAN_W-1:0]    link_wr;
  logic                 link_we;
  logic [REQ_W-1:0]     size_sel;
  logic [SUM_W-1:0]     rounded;
  logic [SUM_W-1:0]     sum;
  logic [LIMIT_W-1:0]   limit;
  logic                 fresh_ok;
  logic                 do_pop;
  logic                 do_fresh;
  logic                 do_push;
  logic [ADDR_W-1:0]    res_addr;
  status_t              res_status;

  // Decode the incoming class
  assign class_in     = class_of(in_req);
  assign class_in_idx = class_in[CLS_IDX_W-1:0];

  // Latch the beat and the head of its class
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_cmd    <= in_cmd;
      item_req    <= in_req;
      item_baddr  <= in_baddr;
      item_class  <= class_in;
      item_hvalid <= head_valid[class_in_idx];
      item_hgran  <= head_gran[class_in_idx];
    end
  end

  // Link store: read the head's successor on accept, push on a free
  scfl_ram #(
    .WIDTH (GRAN_W),
    .DEPTH (GRAN_COUNT)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (free_gran),
    .wdata (link_wr),
    .re    (ctl.accept),
    .raddr (head_gran[class_in_idx]),
    .rdata (link_rd)
  );

  // Resolve the item
  assign is_cls    = (item_class < CLS_W'(NUM_CLASSES));
  assign ci        = item_class[CLS_IDX_W-1:0];
  assign free_gran = item_baddr[ADDR_W-1:GRAN_SHIFT];
  assign link_wr   = item_hvalid ? item_hgran : free_gran;

  always_comb begin
    size_sel  = is_cls ? REQ_W'(MIN_CLASS_BYTES << ci) : item_req;
    rounded   = (SUM_W'(size_sel) + SUM_W'(GRANULE_BYTES - 1)) &
                ~SUM_W'(GRANULE_BYTES - 1);
    sum       = SUM_W'(bump) + rounded;
    limit     = (region_limit > LIMIT_W'(POOL_BYTES)) ? LIMIT_W'(POOL_BYTES) : region_limit;
    fresh_ok  = (sum <= SUM_W'(limit));
    bump_next = sum[LIMIT_W-1:0];
    do_pop    = (item_cmd == CMD_ALLOC) && is_cls && item_hvalid;
    do_fresh  = (item_cmd == CMD_ALLOC) && !do_pop && fresh_ok;
    do_push   = (item_cmd == CMD_FREE) && is_cls;
    link_we   = ctl.execute && do_push;

    res_addr   = '0;
    res_status = STAT_OOM;
    if (item_cmd == CMD_FREE) begin
      res_addr   = item_baddr;
      res_status = do_push ? STAT_FREED : STAT_DROPPED;
    end else if (do_pop) begin
      res_addr   = {item_hgran, GRAN_SHIFT'(0)};
      res_status = STAT_REUSED;
    end else if (do_fresh) begin
      res_addr   = bump[ADDR_W-1:0];
      res_status = STAT_FRESH;
    end
  end

  // Head valid bits: pop the last block or push a block
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_valid[i] <= 1'b0;
      end
    end else if (ctl.execute) begin
      if (do_pop && (link_rd == item_hgran)) begin
        head_valid[ci] <= 1'b0;
      end else if (do_push) begin
        head_valid[ci] <= 1'b1;
      end
    end
  end

  // Head granule: advance on pop, replace on push
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      if (do_pop && (link_rd != item_hgran)) begin
        head_gran[ci] <= link_rd;
      end else if (do_push) begin
        head_gran[ci] <= free_gran;
      end
    end
  end

  // Bump carver
  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
    end else if (ctl.execute && do_fresh) begin
      bump <= bump_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      out_addr   <= res_addr;
      out_status <= res_status;
      out_class  <= item_class;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  // Carver never runs past the pool
  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    bump <= LIMIT_W'(POOL_BYTES))
    else $error("bump pointer beyond pool");

  // Bump pointer moves only when an item resolves
  a_bump_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.execute |=> $stable(bump))
    else $error("bump pointer moved without an item");

  // Out of memory reports a zero address
  a_oom_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == STAT_OOM)) |-> (out_addr == '0))
    else $error("out of memory with nonzero address");

  // Allocated blocks are granule aligned
  a_alloc_align: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_status == STAT_FRESH) || (out_status == STAT_REUSED)))
      |-> (out_addr[GRAN_SHIFT-1:0] == '0))
    else $error("allocated block not granule aligned");

endmodule

### hdl/size_class_free_list_allocator_core.sv
// Size-class free-list allocator: one result beat per request beat.
// The link store is read as the request beat is taken; the resolve state then loads the
// result into the output register once it has room, and only then is a new request taken;
// a result held by m_tready keeps the next request waiting in the resolve state.
// Reset: all class lists empty, bump pointer zero, region_limit 1048576; the
// link store is not cleared (an entry is used only after a free has written it).
`timescale 1ns / 1ps

module size_class_free_list_allocator_core
  import scfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // [20:0] req_bytes, [40:21] block_addr, [47:41] zero
  input  logic [0:0]  s_tuser,  // [0] cmd
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [19:0] addr, [23:20] size_class
  output logic [2:0]  m_tuser,  // [2:0] status
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t            ctl;
  dp_stat_t           stat;
  logic [LIMIT_W-1:0] region_limit;
  logic [ADDR_W-1:0]  res_addr;
  logic [CLS_W-1:0]   res_class;
  logic [STATUS_W-1:0] res_status;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REGION_LIMIT)) begin
      region_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REGION_LIMIT) begin
      prdata = 32'(region_limit);
    end
  end

  scfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  scfl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .in_cmd       (s_tuser[0]),
    .in_req       (s_tdata[REQ_W-1:0]),
    .in_baddr     (s_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .region_limit (region_limit),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_addr     (res_addr),
    .out_status   (res_status),
    .out_class    (res_class)
  );

  // Pack the result beat
  assign m_tdata = {res_class, res_addr};
  assign m_tuser = res_status;

endmodule

### dv/size_class_free_list_allocator_core_tb.sv
// Self-checking testbench for size_class_free_list_allocator_core: request and result
// streams with random idling, an APB-style region_limit register, and an internal
// predictor of the class lists and bump carver. Depends on scfl_pkg and the core only.
`timescale 1ns / 1ps

module size_class_free_list_allocator_core_tb;
  import scfl_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int RUN_LIMIT_NS = 6_000_000;
  localparam logic [2:0] LIMIT_REG_ADDR = 3'({REG_REGION_LIMIT, 2'b00});
  localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int unsigned BIG_CLASS_BYTES = MIN_CLASS_BYTES << (NUM_CLASSES - 1);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
    logic [CLS_W-1:0]  size_class;
  } alloc_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CLS_W-1:0]  size_class;
  } live_block_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [20:0] req_bytes, [40:21] block_addr, [47:41] zero
  logic [0:0]  s_tuser = '0;   // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [19:0] addr, [23:20] size_class
  logic [2:0]  m_tuser;        // [2:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted allocator state
  logic              head_valid [NUM_CLASSES];
  logic [GRAN_W-1:0] head_gran  [NUM_CLASSES];
  logic [GRAN_W-1:0] next_gran  [GRAN_COUNT];
  int unsigned       bump_bytes;
  int unsigned       region_limit;

  alloc_beat_t alloc_results_due [$];
  live_block_t live_blocks [$];

  int src_idle_pct = 34;
  int snk_idle_pct = 80;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int limit_writes = 0;
  int status_seen [5] = '{default: 0};

  size_class_free_list_allocator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Smallest class that covers the size; NUM_CLASSES when oversize
  function automatic int unsigned class_for(input logic [REQ_W-1:0] bytes);
    int unsigned c;
    c = 0;
    while (c < NUM_CLASSES && (MIN_CLASS_BYTES << c) < bytes) c++;
    return c;
  endfunction

  // Advance the predicted state by one request and return its result beat
  function automatic alloc_beat_t predict_alloc(input logic cmd,
                                                input logic [REQ_W-1:0] bytes,
                                                input logic [ADDR_W-1:0] baddr);
    alloc_beat_t       r;
    int unsigned       cls;
    int unsigned       size;
    int unsigned       rounded;
    int unsigned       lim;
    logic [GRAN_W-1:0] g;
    logic [GRAN_W-1:0] nxt;
    cls = class_for(bytes);
    r.addr = '0;
    r.size_class = CLS_W'(cls);
    if (cmd == CMD_ALLOC) begin
      if (cls < NUM_CLASSES && head_valid[cls]) begin
        // pop; a self-link marks the last block of the list
        g = head_gran[cls];
        nxt = next_gran[g];
        r.addr = ADDR_W'(g) << GRAN_SHIFT;
        if (nxt == g) head_valid[cls] = 1'b0;
        else head_gran[cls] = nxt;
        r.status = STAT_REUSED;
      end else begin
        // carve from the bump pointer in whole granules
        size = (cls < NUM_CLASSES) ? (MIN_CLASS_BYTES << cls) : bytes;
        rounded = (size + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
        lim = (region_limit > POOL_BYTES) ? POOL_BYTES : region_limit;
        if (bump_bytes + rounded > lim) begin
          r.status = STAT_OOM;
        end else begin
          r.addr = ADDR_W'(bump_bytes);
          bump_bytes += rounded;
          r.status = STAT_FRESH;
        end
      end
    end else begin
      r.addr = baddr;
      g = GRAN_W'(baddr >> GRAN_SHIFT);
      if (cls >= NUM_CLASSES) begin
        r.status = STAT_DROPPED;
      end else begin
        // push; an empty list gets a self-linked head
        next_gran[g] = head_valid[cls] ? head_gran[cls] : g;
        head_valid[cls] = 1'b1;
        head_gran[cls] = g;
        r.status = STAT_FREED;
      end
    end
    return r;
  endfunction

  // Random byte count that falls in the given class
  function automatic logic [REQ_W-1:0] bytes_in_class(input int unsigned cls);
    if (cls == 0) return ($urandom_range(3) == 0) ? '0 : REQ_W'($urandom_range(1, 32));
    return REQ_W'($urandom_range((MIN_CLASS_BYTES << (cls - 1)) + 1, MIN_CLASS_BYTES << cls));
  endfunction

  // Send one request beat, holding off first as the sender idle rate asks
  task automatic send_req(input logic cmd, input logic [REQ_W-1:0] bytes,
                          input logic [ADDR_W-1:0] baddr, output alloc_beat_t result);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, baddr, bytes};
    do @(posedge clk); while (s_tready !== 1'b1);
    result = predict_alloc(cmd, bytes, baddr);
    alloc_results_due.push_back(result);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted beat has come back
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (alloc_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then idle
  task automatic apb_access(input logic is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= LIMIT_REG_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_region_limit;
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(region_limit)) begin
      errors++;
      $display("%0t: region_limit readback mismatch: expected %0d, got %0d",
               $time, region_limit, rd);
    end
  endtask

  task automatic write_region_limit(input int unsigned value);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, 32'(value & LIMIT_MAX), rd);
    region_limit = value & LIMIT_MAX;
    limit_writes++;
    check_region_limit();
  endtask

  // Tiny and zero limits, reuse with no room left, and a limit write above the pool
  task automatic test_region_limit;
    alloc_beat_t r;
    check_region_limit();
    write_region_limit(MIN_CLASS_BYTES);
    send_req(CMD_ALLOC, 21'd32, '0, r);
    send_req(CMD_ALLOC, 21'd1, '0, r);
    send_req(CMD_ALLOC, 21'd33, '0, r);
    write_region_limit(0);
    send_req(CMD_ALLOC, 21'd0, '0, r);
    send_req(CMD_FREE, 21'd0, 20'd0, r);
    send_req(CMD_ALLOC, 21'd20, 20'hFFFFF, r);
    write_region_limit(LIMIT_MAX);
    write_region_limit(LIMIT_RESET);
  endtask

  // Field extremes, self-linked lists, unaligned and dropped frees, LIFO order
  task automatic test_directed_cases;
    alloc_beat_t r;
    alloc_beat_t blk_small;
    alloc_beat_t blk_big;
    alloc_beat_t blk_d;
    alloc_beat_t blk_e;
    send_req(CMD_ALLOC, 21'd0, 20'd0, blk_small);
    send_req(CMD_ALLOC, REQ_W'(BIG_CLASS_BYTES), 20'd0, blk_big);
    send_req(CMD_ALLOC, REQ_W'(BIG_CLASS_BYTES + 1), 20'd0, r);
    send_req(CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF, r);
    // free the head twice: the list ends at that block, one pop empties it
    send_req(CMD_FREE, 21'd1, blk_small.addr, r);
    send_req(CMD_FREE, 21'd32, blk_small.addr, r);
    send_req(CMD_ALLOC, 21'd17, 20'd0, r);
    send_req(CMD_ALLOC, 21'd32, 20'd0, r);
    // unaligned free comes back aligned
    send_req(CMD_FREE, 21'd2049, blk_big.addr | 20'd31, r);
    send_req(CMD_ALLOC, 21'd4000, 20'd0, r);
    // oversize frees are dropped
    send_req(CMD_FREE, REQ_W'(BIG_CLASS_BYTES + 1), 20'h00040, r);
    send_req(CMD_FREE, 21'h1FFFFF, 20'hFFFFF, r);
    // top granule of the pool
    send_req(CMD_FREE, 21'd32, 20'hFFFFF, r);
    send_req(CMD_ALLOC, 21'd31, 20'd0, r);
    // two-deep list pops in LIFO order, then carves
    send_req(CMD_ALLOC, 21'd256, 20'd0, blk_d);
    send_req(CMD_ALLOC, 21'd200, 20'd0, blk_e);
    send_req(CMD_FREE, 21'd129, blk_d.addr, r);
    send_req(CMD_FREE, 21'd256, blk_e.addr, r);
    send_req(CMD_ALLOC, 21'd256, 20'd0, r);
    send_req(CMD_ALLOC, 21'd256, 20'd0, r);
    send_req(CMD_ALLOC, 21'd256, 20'd0, r);
  endtask

  // Mostly allocate/free of live blocks, plus double frees, stray frees and oversize
  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
    alloc_beat_t r;
    live_block_t blk;
    live_block_t last_freed;
    logic        have_last;
    int          pick;
    int          idx;
    int unsigned cls;
    logic [ADDR_W-1:0] baddr;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    have_last = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 80 && live_blocks.size() == 0)) begin
        cls = ($urandom_range(9) == 0) ? $urandom_range(NUM_CLASSES - 1) : $urandom_range(4);
        send_req(CMD_ALLOC, bytes_in_class(cls), ADDR_W'($urandom), r);
        if ((r.status == STAT_FRESH || r.status == STAT_REUSED) && r.size_class < NUM_CLASSES)
          live_blocks.push_back('{r.addr, r.size_class});
      end else if (pick < 80) begin
        idx = $urandom_range(live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        baddr = blk.addr;
        if ($urandom_range(7) == 0) baddr = baddr | ADDR_W'($urandom_range(GRANULE_BYTES - 1));
        send_req(CMD_FREE, bytes_in_class(blk.size_class), baddr, r);
        last_freed = blk;
        have_last = 1'b1;
      end else if (pick < 86 && have_last) begin
        send_req(CMD_FREE, bytes_in_class(last_freed.size_class), last_freed.addr, r);
      end else if (pick < 94) begin
        send_req(CMD_FREE, bytes_in_class($urandom_range(NUM_CLASSES - 1)),
                 ADDR_W'($urandom), r);
      end else if (pick < 97) begin
        send_req(CMD_FREE, REQ_W'($urandom_range(LIMIT_MAX)), ADDR_W'($urandom), r);
      end else begin
        send_req(CMD_ALLOC, REQ_W'($urandom_range(BIG_CLASS_BYTES + 1, 2 * BIG_CLASS_BYTES)),
                 ADDR_W'($urandom), r);
      end
    end
  endtask

  // Stall the result side at the current rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin : check_results
    alloc_beat_t       want;
    logic [ADDR_W-1:0] got_addr;
    logic [CLS_W-1:0]  got_cls;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got_addr = m_tdata[ADDR_W-1:0];
      got_cls  = m_tdata[ADDR_W +: CLS_W];
      if (alloc_results_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with none pending: addr %h status %0d class %0d",
                 $time, got_addr, m_tuser, got_cls);
      end else begin
        want = alloc_results_due.pop_front();
        results_seen++;
        status_seen[want.status]++;
        if (got_addr !== want.addr) begin
          errors++;
          $display("%0t: addr mismatch: expected %h, got %h", $time, want.addr, got_addr);
        end
        if (m_tuser !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, m_tuser);
        end
        if (got_cls !== want.size_class) begin
          errors++;
          $display("%0t: size_class mismatch: expected %0d, got %0d",
                   $time, want.size_class, got_cls);
        end
      end
    end
  end

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_valid[c] = 1'b0;
      head_gran[c] = '0;
    end
    bump_bytes = 0;
    region_limit = LIMIT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_region_limit();
    test_directed_cases();
    test_random_traffic(34, 80, 470);
    // squeeze the carver so the next phase runs out of memory
    write_region_limit(bump_bytes + 16384);
    test_random_traffic(80, 34, 470);
    write_region_limit(LIMIT_MAX);
    test_random_traffic(0, 0, 460);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d reused, %0d fresh, %0d oom,",
             items_sent, results_seen, status_seen[STAT_REUSED], status_seen[STAT_FRESH],
             status_seen[STAT_OOM]);
    $display("  %0d freed, %0d dropped), %0d region_limit writes, bump at %0d bytes",
             status_seen[STAT_FREED], status_seen[STAT_DROPPED], limit_writes, bump_bytes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT_NS;
    $display("%0t: timeout with %0d results still pending", $time, alloc_results_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/scfl_pkg.sv
hdl/scfl_ram.sv
hdl/scfl_ctrl.sv
hdl/scfl_dp.sv
hdl/size_class_free_list_allocator_core.sv
dv/size_class_free_list_allocator_core_tb.sv
